// ===== design/pendulum_euler_step_assert.svh =====
// Assertion macros used by the pendulum stepper checker.
`ifndef PENDULUM_EULER_STEP_ASSERT_SVH
`define PENDULUM_EULER_STEP_ASSERT_SVH

// Same-cycle implication, sampled on clk and gated by reset.
`define PES_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pendulum_euler_step assertion failed");

// Next-cycle implication, sampled on clk and gated by reset.
`define PES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pendulum_euler_step assertion failed");

`endif

// ===== design/pes_pkg.sv =====
// Package with constants, types and lookup tables for the pendulum stepper.
package pes_pkg;

    localparam int SUBSTEPS    = 10;
    localparam int SINE_DEPTH  = 256;
    localparam int TANH_DEPTH  = 256;
    localparam int SIN_BITS    = $clog2(SINE_DEPTH);
    localparam int TANH_BITS   = $clog2(TANH_DEPTH);
    localparam int SUB_W       = $clog2(SUBSTEPS + 1);
    localparam int ADDR_W      = 5;

    localparam logic [15:0] ANGLE_PI      = 16'h8000;
    localparam logic [30:0] INV_TWO_PI_Q32 = 31'd683565276;
    localparam longint ONE_Q30 = 64'sd1073741824;

    typedef enum logic [2:0] {
        REG_FORCE_GAIN  = 3'd0,
        REG_FLUID       = 3'd1,
        REG_GRAVITY     = 3'd2,
        REG_LEN_MASS    = 3'd3,
        REG_DRY         = 3'd4,
        REG_TIME_STEP   = 3'd5,
        REG_TOP_BAND    = 3'd6,
        REG_UNUSED      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [23:0] force_gain;
        logic [23:0] fluid_friction;
        logic [23:0] gravity_over_length;
        logic [23:0] length_over_mass;
        logic [23:0] dry_friction;
        logic [15:0] time_step;
        logic [15:0] top_band;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic gain;
        logic motor;
        logic ph_a;
        logic ph_b;
        logic ph_c;
        logic sense;
        logic emit;
    } pes_cmd_t;

    typedef struct packed {
        logic place;
    } pes_status_t;

    typedef logic signed [15:0] sine_tab_t [SINE_DEPTH];
    typedef logic [14:0] tanh_tab_t [TANH_DEPTH];

    // Shift-and-subtract quotient of two non-negative values.
    function automatic longint udiv(input longint num, input longint den);
        longint q;
        longint rem;
        q = 64'sd0;
        rem = 64'sd0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    function automatic longint quarter_sine(input longint z);
        longint z2;
        longint p;
        longint r;
        z2 = (z * z) >>> 30;
        p = 64'sd172272;
        p = 64'sd5026995 - ((z2 * p) >>> 30);
        p = 64'sd85569306 - ((z2 * p) >>> 30);
        p = 64'sd693598668 - ((z2 * p) >>> 30);
        p = 64'sd1686629713 - ((z2 * p) >>> 30);
        r = (((z * p) >>> 30) + 64'sd16384) >>> 15;
        return (r > 64'sd32767) ? 64'sd32767 : r;
    endfunction

    function automatic sine_tab_t make_sine_tab();
        sine_tab_t tab;
        longint ph;
        longint f;
        longint q;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            ph = longint'(i) <<< (32 - SIN_BITS);
            f = ph & 64'sh3FFF_FFFF;
            if (ph[30])
            begin
                f = ONE_Q30 - f;
            end
            q = quarter_sine(f);
            if (ph[31])
            begin
                q = -q;
            end
            tab[i] = q[15:0];
        end
        return tab;
    endfunction

    function automatic tanh_tab_t make_tanh_tab();
        tanh_tab_t tab;
        longint a;
        longint t;
        longint t2;
        longint r;
        for (int i = 0; i < TANH_DEPTH; i++)
        begin
            a = longint'(i) <<< (25 - TANH_BITS);
            t = a - udiv((((a * a) >>> 30) * a) >>> 30, 64'sd3);
            for (int k = 0; k < 8; k++)
            begin
                t2 = (t * t) >>> 30;
                t = udiv(t <<< 31, ONE_Q30 + t2);
            end
            r = (t + 64'sd16384) >>> 15;
            if (r > 64'sd32767)
            begin
                r = 64'sd32767;
            end
            tab[i] = r[14:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = make_sine_tab();
    localparam tanh_tab_t TANH_TAB = make_tanh_tab();

endpackage

// ===== design/pes_regs.sv =====
// Configuration register file behind the APB-style port.
module pes_regs
    import pes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.force_gain          <= 24'd65536;
            cfg_reg.fluid_friction      <= 24'd0;
            cfg_reg.gravity_over_length <= 24'd655360;
            cfg_reg.length_over_mass    <= 24'd65536;
            cfg_reg.dry_friction        <= 24'd13107;
            cfg_reg.time_step           <= 16'd66;
            cfg_reg.top_band            <= 16'd3277;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FORCE_GAIN: cfg_reg.force_gain          <= pwdata[23:0];
                REG_FLUID:      cfg_reg.fluid_friction      <= pwdata[23:0];
                REG_GRAVITY:    cfg_reg.gravity_over_length <= pwdata[23:0];
                REG_LEN_MASS:   cfg_reg.length_over_mass    <= pwdata[23:0];
                REG_DRY:        cfg_reg.dry_friction        <= pwdata[23:0];
                REG_TIME_STEP:  cfg_reg.time_step           <= pwdata[15:0];
                REG_TOP_BAND:   cfg_reg.top_band            <= pwdata[15:0];
                REG_UNUSED:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_FORCE_GAIN: prdata = {8'd0, cfg_reg.force_gain};
            REG_FLUID:      prdata = {8'd0, cfg_reg.fluid_friction};
            REG_GRAVITY:    prdata = {8'd0, cfg_reg.gravity_over_length};
            REG_LEN_MASS:   prdata = {8'd0, cfg_reg.length_over_mass};
            REG_DRY:        prdata = {8'd0, cfg_reg.dry_friction};
            REG_TIME_STEP:  prdata = {16'd0, cfg_reg.time_step};
            REG_TOP_BAND:   prdata = {16'd0, cfg_reg.top_band};
            REG_UNUSED:     prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/pes_ctrl.sv =====
// Controller state machine sequencing the force, substep and output phases.
module pes_ctrl
    import pes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_valid,
    output logic        step_stall,
    output logic        result_valid,
    input  logic        result_stall,
    input  pes_status_t status,
    output pes_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FORCE,
        S_MOTOR,
        S_SUB_A,
        S_SUB_B,
        S_SUB_C,
        S_SENSE,
        S_EMIT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [SUB_W-1:0] sub_reg;
    logic [SUB_W-1:0] sub_next;
    logic             valid_reg;
    logic             valid_next;
    logic             out_blocked;

    assign out_blocked  = valid_reg && result_stall;
    assign step_stall   = (state_reg != S_IDLE);
    assign result_valid = valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        sub_next   = sub_reg;
        valid_next = valid_reg && result_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (step_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.place ? S_SENSE : S_FORCE;
                end
            end
            S_FORCE:
            begin
                cmd.gain   = 1'b1;
                state_next = S_MOTOR;
            end
            S_MOTOR:
            begin
                cmd.motor  = 1'b1;
                sub_next   = '0;
                state_next = S_SUB_A;
            end
            S_SUB_A:
            begin
                cmd.ph_a   = 1'b1;
                state_next = S_SUB_B;
            end
            S_SUB_B:
            begin
                cmd.ph_b   = 1'b1;
                state_next = S_SUB_C;
            end
            S_SUB_C:
            begin
                cmd.ph_c = 1'b1;
                sub_next = sub_reg + SUB_W'(1);
                if (sub_reg == SUB_W'(SUBSTEPS - 1))
                begin
                    state_next = S_SENSE;
                end
                else
                begin
                    state_next = S_SUB_A;
                end
            end
            S_SENSE:
            begin
                cmd.sense  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_blocked)
                begin
                    cmd.emit   = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sub_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== design/pes_dp.sv =====
// Datapath holding the pendulum state, the Euler arithmetic and the result registers.
module pes_dp
    import pes_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  pes_cmd_t           cmd,
    output pes_status_t        status,
    input  logic               mode,
    input  logic signed [15:0] action,
    input  logic signed [15:0] start_offset,
    output logic signed [15:0] angle_sense,
    output logic signed [15:0] velocity_sense,
    output logic signed [31:0] motor_force,
    output logic               at_top
);

    logic [15:0]        angle_reg;
    logic signed [31:0] vel_reg;
    logic signed [31:0] force_reg;
    logic signed [15:0] act_reg;
    logic signed [40:0] motor_reg;
    logic signed [56:0] fl_reg;
    logic signed [40:0] gr_reg;
    logic signed [48:0] vd_reg;
    logic signed [43:0] acc_reg;
    logic [15:0]        delta_reg;
    logic [30:0]        x_reg;
    logic signed [15:0] as_reg;
    logic signed [15:0] vs_reg;
    logic signed [31:0] mf_reg;
    logic               top_reg;

    logic signed [40:0] force_prod;
    logic signed [56:0] motor_prod;
    logic signed [15:0] sin_val;
    logic signed [43:0] acc_sum;
    logic signed [32:0] r_val;
    logic signed [63:0] dl_prod;
    logic signed [60:0] av_prod;
    logic signed [45:0] v_sum;
    logic signed [31:0] v_sat;
    logic [32:0]        mag;
    logic [62:0]        x_prod;
    logic [14:0]        tanh_mag;
    logic signed [15:0] vs_val;
    logic [16:0]        abs_sense;
    logic signed [17:0] top_limit;

    assign status.place = mode;

    assign force_prod = $signed({1'b0, cfg.force_gain}) * act_reg;
    assign motor_prod = force_reg * $signed({1'b0, cfg.length_over_mass});
    assign sin_val    = SINE_TAB[angle_reg[15 -: SIN_BITS]];

    assign acc_sum = 44'(motor_reg)
                   - 44'(fl_reg >>> 16)
                   - 44'(gr_reg >>> 15)
                   - ((vel_reg > 0) ? 44'(cfg.dry_friction) : 44'sd0)
                   + ((vel_reg < 0) ? 44'(cfg.dry_friction) : 44'sd0);
    assign r_val   = 33'(vd_reg >>> 16);
    assign dl_prod = r_val * $signed({1'b0, INV_TWO_PI_Q32});
    assign av_prod = acc_reg * $signed({1'b0, cfg.time_step});
    assign v_sum   = 46'(vel_reg) + 46'(av_prod >>> 16);

    always_comb
    begin
        if (v_sum > 46'sd2147483647)
        begin
            v_sat = 32'sh7FFF_FFFF;
        end
        else if (v_sum < -46'sd2147483648)
        begin
            v_sat = 32'sh8000_0000;
        end
        else
        begin
            v_sat = v_sum[31:0];
        end
    end

    assign mag    = vel_reg[31] ? 33'(-34'(vel_reg)) : 33'(vel_reg);
    assign x_prod = 63'(mag) * 63'(INV_TWO_PI_Q32);

    always_comb
    begin
        if (x_reg[30:19] != 12'd0)
        begin
            tanh_mag = 15'h7FFF;
        end
        else
        begin
            tanh_mag = TANH_TAB[x_reg[18 -: TANH_BITS]];
        end
    end

    assign vs_val    = vel_reg[31] ? -$signed({1'b0, tanh_mag}) : $signed({1'b0, tanh_mag});
    assign abs_sense = angle_reg[15] ? 17'(-18'($signed(angle_reg))) : 17'(angle_reg);
    assign top_limit = 18'sd32768 - $signed({2'b00, cfg.top_band});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= ANGLE_PI;
            vel_reg   <= '0;
            force_reg <= '0;
        end
        else
        begin
            if (cmd.load && mode)
            begin
                angle_reg <= ANGLE_PI + start_offset;
                vel_reg   <= '0;
            end
            if (cmd.gain)
            begin
                force_reg <= 32'(force_prod >>> 15);
            end
            if (cmd.ph_c)
            begin
                angle_reg <= angle_reg + delta_reg;
                vel_reg   <= v_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
        end
        if (cmd.motor)
        begin
            motor_reg <= 41'(motor_prod >>> 16);
        end
        if (cmd.ph_a)
        begin
            fl_reg <= $signed({1'b0, cfg.fluid_friction}) * vel_reg;
            gr_reg <= $signed({1'b0, cfg.gravity_over_length}) * sin_val;
            vd_reg <= vel_reg * $signed({1'b0, cfg.time_step});
        end
        if (cmd.ph_b)
        begin
            acc_reg   <= acc_sum;
            delta_reg <= dl_prod[47:32];
        end
        if (cmd.sense)
        begin
            x_reg <= x_prod[62:32];
        end
        if (cmd.emit)
        begin
            as_reg  <= $signed(angle_reg);
            vs_reg  <= vs_val;
            mf_reg  <= force_reg;
            top_reg <= $signed({1'b0, abs_sense}) > top_limit;
        end
    end

    assign angle_sense    = as_reg;
    assign velocity_sense = vs_reg;
    assign motor_force    = mf_reg;
    assign at_top         = top_reg;

endmodule

// ===== design/pendulum_euler_step.sv =====
// Top level of the driven pendulum Euler stepper.
//  channel  | handshake                  | payload
//  step     | step_valid / step_stall    | mode, action, start_offset
//  result   | result_valid / result_stall| angle_sense, velocity_sense, motor_force, at_top
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata
// A step request runs the force and motor phases, then the Euler substep loop of phases A,
// B and C once per substep, then sense and emit; a place request goes straight to sense and emit.
// Reset puts the pole at pi with zero velocity and force and loads the register defaults.
// A new request is taken while a finished result still waits on result_stall;
// the block then holds before writing its next result until the old one is taken.
module pendulum_euler_step
    import pes_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               step_valid,
    output logic               step_stall,
    input  logic               mode,
    input  logic signed [15:0] action,
    input  logic signed [15:0] start_offset,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] angle_sense,
    output logic signed [15:0] velocity_sense,
    output logic signed [31:0] motor_force,
    output logic               at_top
);

    cfg_t        cfg;
    pes_cmd_t    cmd;
    pes_status_t status;

    pes_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pes_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (step_valid),
        .step_stall   (step_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    pes_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .mode           (mode),
        .action         (action),
        .start_offset   (start_offset),
        .angle_sense    (angle_sense),
        .velocity_sense (velocity_sense),
        .motor_force    (motor_force),
        .at_top         (at_top)
    );

endmodule

// ===== design/pes_checker.sv =====
// Port-level checker for the pendulum stepper, bound to the top level.
`include "pendulum_euler_step_assert.svh"

module pes_checker
    import pes_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               step_valid,
    input logic               step_stall,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [31:0] motor_force
);

    `PES_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
    `PES_ASSERT_NEXT(a_force_held, result_valid && result_stall, $stable(motor_force))
    `PES_ASSERT_NEXT(a_busy_after_request, step_valid && !step_stall, step_stall)
    `PES_ASSERT_NOW(a_result_from_busy, $rose(result_valid), $past(step_stall))

endmodule

bind pendulum_euler_step pes_checker u_pes_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_valid   (step_valid),
    .step_stall   (step_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .motor_force  (motor_force)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the driven pendulum Euler stepper.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pes_pkg::*;

    localparam longint INV_TWO_PI = 64'sd683565276;
    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam int     CYCLE_LIMIT = 600000;

    typedef struct {
        logic signed [15:0] angle_sense;
        logic signed [15:0] velocity_sense;
        logic signed [31:0] motor_force;
        logic               at_top;
    } pendulum_out_t;

    class pendulum_scoreboard;
        logic [23:0] force_gain, fluid_friction, gravity_over_length;
        logic [23:0] length_over_mass, dry_friction;
        logic [15:0] time_step, top_band;
        logic [15:0] pole_angle;
        longint      pole_velocity;
        logic signed [31:0] pole_force;
        longint      sine_lut[SINE_DEPTH];
        longint      tanh_lut[TANH_DEPTH];
        pendulum_out_t expected_q[$];
        int          errors;

        function new();
            for (int i = 0; i < SINE_DEPTH; i++)
            begin
                sine_lut[i] = sine_q15(i);
            end
            for (int i = 0; i < TANH_DEPTH; i++)
            begin
                tanh_lut[i] = tanh_q15(i);
            end
            force_gain = 24'd65536;
            fluid_friction = 24'd0;
            gravity_over_length = 24'd655360;
            length_over_mass = 24'd65536;
            dry_friction = 24'd13107;
            time_step = 16'd66;
            top_band = 16'd3277;
            pole_angle = ANGLE_PI;
            pole_velocity = 0;
            pole_force = 0;
            errors = 0;
        endfunction

        function longint sine_q15(int idx);
            longint phase, z, z2, p, r;
            int quadrant;
            phase = (longint'(idx) <<< 32) / SINE_DEPTH;
            quadrant = int'((phase >>> 30) & 3);
            z = phase & 64'sh3FFF_FFFF;
            if (quadrant % 2 == 1)
            begin
                z = Q30_ONE - z;
            end
            z2 = (z * z) >>> 30;
            p = 64'sd172272;
            p = 64'sd5026995 - ((z2 * p) >>> 30);
            p = 64'sd85569306 - ((z2 * p) >>> 30);
            p = 64'sd693598668 - ((z2 * p) >>> 30);
            p = 64'sd1686629713 - ((z2 * p) >>> 30);
            r = (((z * p) >>> 30) + 64'sd16384) >>> 15;
            if (r > 32767)
            begin
                r = 32767;
            end
            return (quadrant >= 2) ? -r : r;
        endfunction

        function longint tanh_q15(int idx);
            longint a, t, r;
            a = (longint'(idx) <<< 25) / TANH_DEPTH;
            t = a - (((((a * a) >>> 30) * a) >>> 30) / 3);
            repeat (8)
            begin
                t = (t <<< 31) / (Q30_ONE + ((t * t) >>> 30));
            end
            r = (t + 64'sd16384) >>> 15;
            return (r > 32767) ? 64'sd32767 : r;
        endfunction

        function void write_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_FORCE_GAIN: force_gain = value[23:0];
                REG_FLUID:      fluid_friction = value[23:0];
                REG_GRAVITY:    gravity_over_length = value[23:0];
                REG_LEN_MASS:   length_over_mass = value[23:0];
                REG_DRY:        dry_friction = value[23:0];
                REG_TIME_STEP:  time_step = value[15:0];
                REG_TOP_BAND:   top_band = value[15:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic place, logic signed [15:0] act,
                                   logic signed [15:0] offset);
            pendulum_out_t res;
            longint v, acc, r, delta, mag, x, idx, sense, vs;
            if (place)
            begin
                pole_angle = ANGLE_PI + offset;
                pole_velocity = 0;
            end
            else
            begin
                pole_force = 32'((longint'(force_gain) * longint'(act)) >>> 15);
                v = pole_velocity;
                for (int s = 0; s < SUBSTEPS; s++)
                begin
                    acc = 0;
                    if (v > 0)
                    begin
                        acc = -longint'(dry_friction);
                    end
                    else if (v < 0)
                    begin
                        acc = longint'(dry_friction);
                    end
                    acc -= (longint'(fluid_friction) * v) >>> 16;
                    acc -= (longint'(gravity_over_length) * sine_lut[pole_angle[15:8]]) >>> 15;
                    acc += (longint'(pole_force) * longint'(length_over_mass)) >>> 16;
                    r = (v * longint'(time_step)) >>> 16;
                    delta = (r * INV_TWO_PI) >>> 32;
                    pole_angle = pole_angle + delta[15:0];
                    v = v + ((acc * longint'(time_step)) >>> 16);
                    if (v > 64'sd2147483647)
                    begin
                        v = 64'sd2147483647;
                    end
                    else if (v < -64'sd2147483648)
                    begin
                        v = -64'sd2147483648;
                    end
                end
                pole_velocity = v;
            end
            sense = longint'(signed'(pole_angle));
            mag = (pole_velocity < 0) ? -pole_velocity : pole_velocity;
            x = (mag * INV_TWO_PI) >>> 32;
            idx = (x * TANH_DEPTH) >>> 19;
            vs = (idx >= TANH_DEPTH) ? 64'sd32767 : tanh_lut[idx];
            if (pole_velocity < 0)
            begin
                vs = -vs;
            end
            res.angle_sense = sense[15:0];
            res.velocity_sense = vs[15:0];
            res.motor_force = pole_force;
            res.at_top = (((sense < 0) ? -sense : sense) > 32768 - longint'(top_band));
            expected_q.push_back(res);
        endfunction

        function void check_result(pendulum_out_t got);
            pendulum_out_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.angle_sense !== exp_res.angle_sense)
            begin
                $error("angle_sense: expected %0d, got %0d",
                       exp_res.angle_sense, got.angle_sense);
                errors++;
            end
            if (got.velocity_sense !== exp_res.velocity_sense)
            begin
                $error("velocity_sense: expected %0d, got %0d",
                       exp_res.velocity_sense, got.velocity_sense);
                errors++;
            end
            if (got.motor_force !== exp_res.motor_force)
            begin
                $error("motor_force: expected %0d, got %0d",
                       exp_res.motor_force, got.motor_force);
                errors++;
            end
            if (got.at_top !== exp_res.at_top)
            begin
                $error("at_top: expected %0d, got %0d", exp_res.at_top, got.at_top);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               step_valid;
    logic               step_stall;
    logic               mode;
    logic signed [15:0] action;
    logic signed [15:0] start_offset;
    logic               result_valid;
    logic               result_stall;
    logic signed [15:0] angle_sense;
    logic signed [15:0] velocity_sense;
    logic signed [31:0] motor_force;
    logic               at_top;

    pendulum_scoreboard scoreboard = new();
    int                 cycle_count = 0;
    int                 stall_level = 0;
    int                 burst_left = 0;
    pendulum_out_t      observed;

    pendulum_euler_step dut (.*);

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        step_valid = 1'b0;
        mode = 1'b0;
        action = '0;
        start_offset = '0;
        result_stall = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver stalls with a randomly chosen strength that it redraws periodically, sometimes not at all.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                observed.angle_sense = angle_sense;
                observed.velocity_sense = velocity_sense;
                observed.motor_force = motor_force;
                observed.at_top = at_top;
                scoreboard.check_result(observed);
            end
            if (cycle_count % 64 == 0)
            begin
                stall_level = $urandom_range(0, 4);
            end
            result_stall <= ($urandom_range(0, 3) < stall_level);
        end
    end

    task automatic apb_write(reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        scoreboard.write_register(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_request(logic place, logic signed [15:0] act,
                                logic signed [15:0] offset);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                step_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        mode <= place;
        action <= act;
        start_offset <= offset;
        step_valid <= 1'b1;
        @(posedge clk);
        while (step_stall)
        begin
            @(posedge clk);
        end
        scoreboard.note_request(place, act, offset);
    endtask

    task automatic drain();
        step_valid <= 1'b0;
        @(posedge clk);
        while (scoreboard.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
    endtask

    task automatic load_settings(int setting);
        logic [31:0] value;
        for (int i = 0; i <= int'(REG_TOP_BAND); i++)
        begin
            case (setting)
                0: value = {$urandom} & 32'hFF00_0000;
                1: value = 32'hFFFF_FFFF;
                2: value = (i == int'(REG_TIME_STEP)) ? $urandom_range(600, 4000) :
                           (i == int'(REG_TOP_BAND)) ? 32'h0000_FFFF :
                           $urandom_range(0, 1 << 20);
                default: value = (i == int'(REG_TIME_STEP)) ? $urandom_range(0, 65535) :
                                 (i == int'(REG_TOP_BAND)) ? $urandom_range(0, 32768) :
                                 $urandom_range(0, 24'hFF_FFFF);
            endcase
            value = value | ({$urandom} & 32'hFF00_0000);
            apb_write(reg_idx_t'(i), value);
        end
        apb_write(REG_UNUSED, $urandom);
    endtask

    // Mostly swinging steps with random actions; placements now and then.
    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(1'b1, 16'($urandom), 16'($urandom));
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                send_request(1'b0, ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000),
                             16'($urandom));
            end
            else
            begin
                send_request(1'b0, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pole exactly at pi, placements at the extreme offsets, full actions both ways.
        send_request(1'b0, 16'sh0000, 16'sh0000);
        send_request(1'b1, 16'sh1234, 16'sh0000);
        send_request(1'b1, 16'sh0000, 16'sh7FFF);
        send_request(1'b1, 16'sh0000, 16'sh8000);
        send_request(1'b1, 16'shFFFF, 16'sh4000);
        send_request(1'b0, 16'sh7FFF, 16'shAAAA);
        send_request(1'b0, 16'sh8000, 16'sh5555);
        send_request(1'b0, 16'shFFFF, 16'sh0000);
        send_request(1'b0, 16'sh0001, 16'shFFFF);
        send_request(1'b1, 16'sh0000, 16'sh0001);
        for (int n = 0; n < 8; n++)
        begin
            send_request(1'b0, 16'sh7FFF, 16'sh0000);
        end
        random_phase(120);
        drain();

        for (int setting = 0; setting < 5; setting++)
        begin
            load_settings(setting);
            send_request(1'b1, 16'sh0000, 16'sh0000);
            send_request(1'b0, 16'sh8000, 16'sh0000);
            random_phase((setting == 1) ? 40 : 110);
            drain();
        end
        apb_write(REG_TOP_BAND, 32'h0000_8000);
        apb_write(REG_TIME_STEP, 32'h0000_FFFF);
        random_phase(20);
        drain();

        if (scoreboard.errors == 0 && scoreboard.expected_q.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== pendulum_euler_step.f =====
+incdir+design
design/pes_pkg.sv
design/pes_regs.sv
design/pes_ctrl.sv
design/pes_dp.sv
design/pendulum_euler_step.sv
design/pes_checker.sv
tb/testbench.sv
